// ===== design/ldm_pkg.sv =====
// Shared types and constants of the lens distortion map generator.
// Depends on nothing; the core and the multiplier import it.
package ldm_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned FRAC = 28;
  localparam int unsigned NORM_SH = 48 - FRAC;
  localparam int unsigned DIFF_W = HALF_W + 2;
  localparam int unsigned MAG_W = 61;
  localparam int unsigned VAL_W = MAG_W + 1;
  localparam int unsigned PP_LO_W = 32;
  localparam int unsigned MUL_LAT = 4;

  localparam logic [MAG_W-1:0] ACC_LIM = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] FIX_ONE = VAL_W'(1) << FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER,
    CFG_FOCAL,
    CFG_INV_FOCAL,
    CFG_K1,
    CFG_K2,
    CFG_P1,
    CFG_P2
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic signed [HALF_W-1:0] map_x;
    logic signed [HALF_W-1:0] map_y;
  } out_item_t;

endpackage

// ===== design/lens_undistort_map_generator_core.sv =====
// Brown-Conrady distortion map core: one pixel item per clock, no stall.
// From the edge that takes start to the edge that ends the done_o cycle, an item passes
// through six chained four-stage multipliers plus seven add stages.
// busy stays low, so an item can enter in every cycle; results cannot be held.
// Reset clears the valid pipeline and all configuration registers to zero.
module lens_undistort_map_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  ldm_pkg::in_item_t                 item_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ldm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ldm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              done_o,
  output ldm_pkg::out_item_t                result_o
);
  import ldm_pkg::*;

  localparam int unsigned LATENCY = 6 * MUL_LAT + 7;
  localparam int unsigned D_R2 = MUL_LAT + 1;
  localparam int unsigned D_TAN = 2 * MUL_LAT + 3;
  localparam int unsigned D_SQ = 2 * MUL_LAT + 4;
  localparam int unsigned D_XY = 3 * MUL_LAT + 4;
  localparam logic signed [VAL_W+1:0] SUM_HI = (VAL_W+2)'(ACC_LIM);
  localparam logic signed [VAL_W+1:0] SUM_LO = -SUM_HI;
  localparam logic signed [VAL_W:0] OUT_MAX = $signed({{(VAL_W-30){1'b0}}, {31{1'b1}}});
  localparam logic signed [VAL_W:0] OUT_MIN = -OUT_MAX - 1;

  function automatic logic signed [VAL_W-1:0] sat_sum(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b,
    input logic signed [VAL_W-1:0] c
  );
    logic signed [VAL_W+1:0] s;
    s = (VAL_W+2)'(a) + (VAL_W+2)'(b) + (VAL_W+2)'(c);
    if (s > SUM_HI) begin
      return VAL_W'(SUM_HI);
    end else if (s < SUM_LO) begin
      return VAL_W'(SUM_LO);
    end
    return VAL_W'(s);
  endfunction

  function automatic logic signed [HALF_W-1:0] rescale(
    input logic signed [VAL_W-1:0] p,
    input logic [HALF_W-1:0] c
  );
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(p) + $signed((VAL_W+1)'(c));
    if (s > OUT_MAX) begin
      return HALF_W'(OUT_MAX);
    end else if (s < OUT_MIN) begin
      return HALF_W'(OUT_MIN);
    end
    return HALF_W'(s);
  endfunction

  logic [CFG_DATA_W-1:0] center_q, focal_q, invf_q;
  logic signed [COEF_W-1:0] k1_q, k2_q, p1_q, p2_q;
  logic signed [COEF_W:0] p1x2_q, p2x2_q;
  logic signed [COEF_W+1:0] p1x3_q, p2x3_q;

  logic [LATENCY-1:0] vld_q;
  logic signed [DIFF_W-1:0] diffx_q, diffy_q;
  logic signed [VAL_W-1:0] nx, ny, x2, y2, tx, ty;
  logic signed [VAL_W-1:0] r2_q, kr2, d1_q, r2_dl, dr2, d_q;
  logic signed [VAL_W-1:0] tx_dl, ty_dl, xs_q, ys_q;
  logic signed [VAL_W-1:0] nx_dl, ny_dl, x2_dl, y2_dl;
  logic signed [VAL_W-1:0] xm, ym, q_p2y2, q_p2x2, q_p1y2, q_p1x2;
  logic signed [VAL_W-1:0] xd_q, yd_q, sx, sy;
  out_item_t result_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      focal_q  <= '0;
      invf_q   <= '0;
      k1_q     <= '0;
      k2_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
      p1x2_q   <= '0;
      p2x2_q   <= '0;
      p1x3_q   <= '0;
      p2x3_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER:    center_q <= cfg_data_i;
        CFG_FOCAL:     focal_q <= cfg_data_i;
        CFG_INV_FOCAL: invf_q <= cfg_data_i;
        CFG_K1:        k1_q <= $signed(cfg_data_i[COEF_W-1:0]);
        CFG_K2:        k2_q <= $signed(cfg_data_i[COEF_W-1:0]);
        CFG_P1: begin
          p1_q   <= $signed(cfg_data_i[COEF_W-1:0]);
          p1x2_q <= $signed({cfg_data_i[COEF_W-1:0], 1'b0});
          p1x3_q <= (COEF_W+2)'($signed(cfg_data_i[COEF_W-1:0]))
                  + (COEF_W+2)'($signed({cfg_data_i[COEF_W-1:0], 1'b0}));
        end
        CFG_P2: begin
          p2_q   <= $signed(cfg_data_i[COEF_W-1:0]);
          p2x2_q <= $signed({cfg_data_i[COEF_W-1:0], 1'b0});
          p2x3_q <= (COEF_W+2)'($signed(cfg_data_i[COEF_W-1:0]))
                  + (COEF_W+2)'($signed({cfg_data_i[COEF_W-1:0], 1'b0}));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    diffx_q <= $signed(DIFF_W'(item_i.pixel_col) << 16)
             - $signed(DIFF_W'(center_q[2*HALF_W-1:HALF_W]));
    diffy_q <= $signed(DIFF_W'(item_i.pixel_row) << 16)
             - $signed(DIFF_W'(center_q[HALF_W-1:0]));
    r2_q    <= sat_sum(x2, y2, '0);
    d1_q    <= sat_sum(VAL_W'(k1_q), kr2, '0);
    d_q     <= sat_sum(FIX_ONE, dr2, '0);
    xs_q    <= sat_sum(d_q, tx_dl, '0);
    ys_q    <= sat_sum(d_q, ty_dl, '0);
    xd_q    <= sat_sum(xm, q_p2y2, q_p2x2);
    yd_q    <= sat_sum(ym, q_p1y2, q_p1x2);
    result_q.map_x <= rescale(sx, center_q[2*HALF_W-1:HALF_W]);
    result_q.map_y <= rescale(sy, center_q[HALF_W-1:0]);
  end

  ldm_mul #(.SH(NORM_SH)) u_mul_nx (
    .clk_i, .a_i(VAL_W'(diffx_q)),
    .b_i($signed(VAL_W'(invf_q[2*HALF_W-1:HALF_W]))), .p_o(nx)
  );
  ldm_mul #(.SH(NORM_SH)) u_mul_ny (
    .clk_i, .a_i(VAL_W'(diffy_q)),
    .b_i($signed(VAL_W'(invf_q[HALF_W-1:0]))), .p_o(ny)
  );

  ldm_mul #(.SH(FRAC)) u_mul_x2 (.clk_i, .a_i(nx), .b_i(nx), .p_o(x2));
  ldm_mul #(.SH(FRAC)) u_mul_y2 (.clk_i, .a_i(ny), .b_i(ny), .p_o(y2));
  ldm_mul #(.SH(FRAC)) u_mul_tx (.clk_i, .a_i(VAL_W'(p1x2_q)), .b_i(ny), .p_o(tx));
  ldm_mul #(.SH(FRAC)) u_mul_ty (.clk_i, .a_i(VAL_W'(p2x2_q)), .b_i(nx), .p_o(ty));

  ldm_mul #(.SH(FRAC)) u_mul_kr2 (.clk_i, .a_i(VAL_W'(k2_q)), .b_i(r2_q), .p_o(kr2));

  ldm_delay #(.WIDTH(VAL_W), .DEPTH(D_R2)) u_dly_r2 (
    .clk_i, .data_i(r2_q), .data_o(r2_dl)
  );
  ldm_mul #(.SH(FRAC)) u_mul_dr2 (.clk_i, .a_i(d1_q), .b_i(r2_dl), .p_o(dr2));

  ldm_delay #(.WIDTH(2 * VAL_W), .DEPTH(D_TAN)) u_dly_tan (
    .clk_i, .data_i({tx, ty}), .data_o({tx_dl, ty_dl})
  );
  ldm_delay #(.WIDTH(2 * VAL_W), .DEPTH(D_XY)) u_dly_xy (
    .clk_i, .data_i({nx, ny}), .data_o({nx_dl, ny_dl})
  );
  ldm_delay #(.WIDTH(2 * VAL_W), .DEPTH(D_SQ)) u_dly_sq (
    .clk_i, .data_i({x2, y2}), .data_o({x2_dl, y2_dl})
  );

  ldm_mul #(.SH(FRAC)) u_mul_xm (.clk_i, .a_i(nx_dl), .b_i(xs_q), .p_o(xm));
  ldm_mul #(.SH(FRAC)) u_mul_ym (.clk_i, .a_i(ny_dl), .b_i(ys_q), .p_o(ym));
  ldm_mul #(.SH(FRAC)) u_mul_p2y2 (
    .clk_i, .a_i(VAL_W'(p2_q)), .b_i(y2_dl), .p_o(q_p2y2)
  );
  ldm_mul #(.SH(FRAC)) u_mul_p2x2 (
    .clk_i, .a_i(VAL_W'(p2x3_q)), .b_i(x2_dl), .p_o(q_p2x2)
  );
  ldm_mul #(.SH(FRAC)) u_mul_p1y2 (
    .clk_i, .a_i(VAL_W'(p1x3_q)), .b_i(y2_dl), .p_o(q_p1y2)
  );
  ldm_mul #(.SH(FRAC)) u_mul_p1x2 (
    .clk_i, .a_i(VAL_W'(p1_q)), .b_i(x2_dl), .p_o(q_p1x2)
  );

  ldm_mul #(.SH(FRAC)) u_mul_sx (
    .clk_i, .a_i($signed(VAL_W'(focal_q[2*HALF_W-1:HALF_W]))), .b_i(xd_q), .p_o(sx)
  );
  ldm_mul #(.SH(FRAC)) u_mul_sy (
    .clk_i, .a_i($signed(VAL_W'(focal_q[HALF_W-1:0]))), .b_i(yd_q), .p_o(sy)
  );

  assign done_o = vld_q[LATENCY-1];
  assign result_o = result_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without an item accepted at the pipeline latency");

  a_zero_fx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(focal_q[2*HALF_W-1:HALF_W] == '0, MUL_LAT + 1)) |->
    ($past(center_q[2*HALF_W-1], 1) ? (result_o.map_x == OUT_MAX[HALF_W-1:0]) :
     (result_o.map_x == $signed($past(center_q[2*HALF_W-1:HALF_W], 1)))))
    else $error("zero horizontal focal length must map to the column centre");

  a_zero_fy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(focal_q[HALF_W-1:0] == '0, MUL_LAT + 1)) |->
    ($past(center_q[HALF_W-1], 1) ? (result_o.map_y == OUT_MAX[HALF_W-1:0]) :
     (result_o.map_y == $signed($past(center_q[HALF_W-1:0], 1)))))
    else $error("zero vertical focal length must map to the row centre");
`endif

endmodule

// ===== design/ldm_delay.sv =====
// Fixed-length shift register that aligns operands between pipeline stages.
// Depends on nothing.
module ldm_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

// ===== design/ldm_mul.sv =====
// Four-stage signed fixed-point multiplier with rounding and saturation.
// Depends on ldm_pkg for the value widths and the saturation limit.
module ldm_mul #(
  parameter int unsigned SH = ldm_pkg::FRAC
) (
  input  logic                              clk_i,
  input  logic signed [ldm_pkg::VAL_W-1:0] a_i,
  input  logic signed [ldm_pkg::VAL_W-1:0] b_i,
  output logic signed [ldm_pkg::VAL_W-1:0] p_o
);
  import ldm_pkg::*;

  localparam int unsigned HI_W = MAG_W - PP_LO_W;
  localparam int unsigned PROD_W = 2 * MAG_W;
  localparam int unsigned RES_W = PROD_W - SH;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SH - 1);
  localparam logic [RES_W-1:0] LIM = RES_W'(ACC_LIM);

  logic [MAG_W-1:0] ma_d, mb_d, ma_q, mb_q;
  logic neg_q1, neg_q2, neg_q3;
  logic [2*PP_LO_W-1:0] pp_ll_q;
  logic [HI_W+PP_LO_W-1:0] pp_hl_q, pp_lh_q;
  logic [2*HI_W-1:0] pp_hh_q;
  logic [PROD_W-1:0] sum_d, sum_q;
  logic [RES_W-1:0] shr;
  logic [MAG_W-1:0] mag;
  logic signed [VAL_W-1:0] p_d, p_q;

  always_comb begin
    ma_d = a_i[VAL_W-1] ? MAG_W'(-a_i) : MAG_W'(a_i);
    mb_d = b_i[VAL_W-1] ? MAG_W'(-b_i) : MAG_W'(b_i);
    sum_d = PROD_W'(pp_ll_q) + (PROD_W'(pp_hl_q) << PP_LO_W)
          + (PROD_W'(pp_lh_q) << PP_LO_W) + (PROD_W'(pp_hh_q) << (2 * PP_LO_W)) + HALF;
    shr = sum_q[PROD_W-1:SH];
    mag = (shr > LIM) ? ACC_LIM : shr[MAG_W-1:0];
    p_d = neg_q3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    neg_q1  <= a_i[VAL_W-1] ^ b_i[VAL_W-1];
    pp_ll_q <= ma_q[PP_LO_W-1:0] * mb_q[PP_LO_W-1:0];
    pp_hl_q <= ma_q[MAG_W-1:PP_LO_W] * mb_q[PP_LO_W-1:0];
    pp_lh_q <= ma_q[PP_LO_W-1:0] * mb_q[MAG_W-1:PP_LO_W];
    pp_hh_q <= ma_q[MAG_W-1:PP_LO_W] * mb_q[MAG_W-1:PP_LO_W];
    neg_q2  <= neg_q1;
    sum_q   <= sum_d;
    neg_q3  <= neg_q2;
    p_q     <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== bench/lens_undistort_map_generator_core_tb.sv =====
// Self-checking testbench of the lens distortion map core, with a fixed-point model of each item.
// It runs directed corner pixels and then random pixels under many register settings and idle mixes.
// Depends on ldm_pkg and lens_undistort_map_generator_core.
module lens_undistort_map_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ldm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned ITEMS_PER_SETTING = 55;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX = CFG_IDX_W'(7);
  localparam longint SAT_LIM = 64'sd1 <<< 60;
  localparam longint MAP_MIN = -(64'sd1 <<< 31);
  localparam longint MAP_MAX = (64'sd1 <<< 31) - 1;

  typedef enum int {
    SET_TYPICAL,
    SET_RANDOM,
    SET_MAX,
    SET_MIN,
    SET_NO_INVERSE
  } setting_e;

  class map_predictor;
    logic [63:0] center;
    logic [63:0] focal;
    logic [63:0] inv_focal;
    longint k1, k2, p1, p2;
    out_item_t pending_maps[$];
    int unsigned mismatches;
    int unsigned checked_maps;

    function new();
      center = '0;
      focal = '0;
      inv_focal = '0;
      k1 = 0;
      k2 = 0;
      p1 = 0;
      p2 = 0;
      mismatches = 0;
      checked_maps = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_CENTER: center = data;
        CFG_FOCAL: focal = data;
        CFG_INV_FOCAL: inv_focal = data;
        CFG_K1: k1 = longint'($signed(data[31:0]));
        CFG_K2: k2 = longint'($signed(data[31:0]));
        CFG_P1: p1 = longint'($signed(data[31:0]));
        CFG_P2: p2 = longint'($signed(data[31:0]));
        default: ;
      endcase
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    static function longint sat(longint v);
      return clip(v, -SAT_LIM, SAT_LIM);
    endfunction

    // Exact product, rounded half away from zero, shifted right and saturated.
    static function longint fix_mul(longint a, longint b, int unsigned sh);
      logic neg;
      logic [63:0] ua, ub;
      logic [127:0] prod;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      prod = (prod + (128'd1 << (sh - 1))) >> sh;
      if (prod > 128'(SAT_LIM)) prod = 128'(SAT_LIM);
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function void note_pixel(in_item_t px);
      longint u, v, u0, v0, fx, fy, ifx, ify;
      longint x, y, x2, y2, r2, d, xd, yd;
      out_item_t map;
      u = longint'(px.pixel_col);
      v = longint'(px.pixel_row);
      u0 = longint'(center[63:32]);
      v0 = longint'(center[31:0]);
      fx = longint'(focal[63:32]);
      fy = longint'(focal[31:0]);
      ifx = longint'(inv_focal[63:32]);
      ify = longint'(inv_focal[31:0]);
      x = fix_mul(u * 65536 - u0, ifx, NORM_SH);
      y = fix_mul(v * 65536 - v0, ify, NORM_SH);
      x2 = fix_mul(x, x, FRAC);
      y2 = fix_mul(y, y, FRAC);
      r2 = sat(x2 + y2);
      d = sat(k1 + fix_mul(k2, r2, FRAC));
      d = sat((64'sd1 <<< FRAC) + fix_mul(d, r2, FRAC));
      xd = sat(d + fix_mul(2 * p1, y, FRAC));
      xd = sat(fix_mul(x, xd, FRAC) + fix_mul(p2, y2, FRAC) + fix_mul(3 * p2, x2, FRAC));
      yd = sat(d + fix_mul(2 * p2, x, FRAC));
      yd = sat(fix_mul(y, yd, FRAC) + fix_mul(3 * p1, y2, FRAC) + fix_mul(p1, x2, FRAC));
      map.map_x = 32'(clip(fix_mul(fx, xd, FRAC) + u0, MAP_MIN, MAP_MAX));
      map.map_y = 32'(clip(fix_mul(fy, yd, FRAC) + v0, MAP_MIN, MAP_MAX));
      pending_maps.push_back(map);
    endfunction

    function void check_map(out_item_t got);
      out_item_t want;
      if (pending_maps.size() == 0) begin
        $error("map item with none pending: map_x %0d, map_y %0d", got.map_x, got.map_y);
        mismatches++;
        return;
      end
      want = pending_maps.pop_front();
      checked_maps++;
      if (got.map_x !== want.map_x) begin
        $error("map_x: expected %0d, actual %0d", want.map_x, got.map_x);
        mismatches++;
      end
      if (got.map_y !== want.map_y) begin
        $error("map_y: expected %0d, actual %0d", want.map_y, got.map_y);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t item_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic done_o;
  out_item_t result_o;

  map_predictor predictor = new();
  int unsigned quiet_cycles = 0;

  lens_undistort_map_generator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      predictor.check_map(result_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] signed_rand(int unsigned mag);
    return 32'(int'($urandom_range(2 * mag)) - int'(mag));
  endfunction

  task automatic load_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    predictor.set_register(idx, data);
  endtask

  task automatic apply_setting(setting_e kind);
    logic [31:0] fx_q, fy_q;
    logic [63:0] center, focal, inv;
    logic [31:0] coef [4];
    fx_q = {16'($urandom_range(200, 4000)), 16'($urandom)};
    fy_q = {16'($urandom_range(200, 4000)), 16'($urandom)};
    center = {4'd0, 12'($urandom_range(4095)), 16'($urandom),
              4'd0, 12'($urandom_range(4095)), 16'($urandom)};
    focal = {fx_q, fy_q};
    inv = {32'((64'd1 << 48) / {32'd0, fx_q}), 32'((64'd1 << 48) / {32'd0, fy_q})};
    coef[0] = signed_rand(1 << 27);
    coef[1] = signed_rand(1 << 25);
    coef[2] = signed_rand(1 << 20);
    coef[3] = signed_rand(1 << 20);
    case (kind)
      SET_RANDOM: begin
        center = {$urandom, $urandom};
        focal = {$urandom, $urandom};
        inv = {$urandom, $urandom};
        foreach (coef[i]) coef[i] = $urandom;
      end
      SET_MAX: begin
        center = '1;
        focal = '1;
        inv = '1;
        foreach (coef[i]) coef[i] = 32'h7fff_ffff;
      end
      SET_MIN: begin
        center = '0;
        focal = '1;
        inv = '1;
        foreach (coef[i]) coef[i] = 32'h8000_0000;
      end
      SET_NO_INVERSE: inv = '0;
      default: ;
    endcase
    load_register(CFG_BAD_IDX, {$urandom, $urandom});
    load_register(CFG_CENTER, center);
    load_register(CFG_FOCAL, focal);
    load_register(CFG_INV_FOCAL, inv);
    load_register(CFG_K1, {$urandom, coef[0]});
    load_register(CFG_K2, {$urandom, coef[1]});
    load_register(CFG_P1, {$urandom, coef[2]});
    load_register(CFG_P2, {$urandom, coef[3]});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                            int unsigned idle_pct);
    in_item_t px;
    int unsigned gap;
    px.pixel_col = col;
    px.pixel_row = row;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= px;
    do @(posedge clk_i); while (busy);
    predictor.note_pixel(px);
  endtask

  task automatic wait_for_maps();
    while (predictor.pending_maps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? '1 : '0;
    return COORD_BITS'($urandom);
  endfunction

  initial begin
    setting_e plan [9];
    int unsigned idle_mix [3];
    logic [COORD_BITS-1:0] u0_px, v0_px;

    plan = '{SET_TYPICAL, SET_RANDOM, SET_MAX, SET_TYPICAL, SET_MIN,
             SET_NO_INVERSE, SET_TYPICAL, SET_RANDOM, SET_TYPICAL};
    idle_mix = '{0, 76, 28};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel('0, '0, 0);
    send_pixel('1, '1, 0);
    send_pixel('0, '1, 0);
    send_pixel('1, '0, 0);
    start <= 1'b0;
    wait_for_maps();

    apply_setting(SET_TYPICAL);
    u0_px = COORD_BITS'(predictor.center[63:48]);
    v0_px = COORD_BITS'(predictor.center[31:16]);
    send_pixel('0, '0, 0);
    send_pixel('1, '1, 0);
    send_pixel('0, '1, 0);
    send_pixel('1, '0, 0);
    send_pixel(12'haaa, 12'h555, 0);
    send_pixel(12'h555, 12'haaa, 0);
    send_pixel(u0_px, v0_px, 0);
    send_pixel(12'd1, 12'd1, 0);
    send_pixel(12'd2048, 12'd2048, 0);
    send_pixel(12'd4094, 12'd1, 0);
    start <= 1'b0;
    wait_for_maps();

    foreach (plan[ph]) begin
      apply_setting(plan[ph]);
      repeat (ITEMS_PER_SETTING) send_pixel(pick_coord(), pick_coord(), idle_mix[ph % 3]);
      start <= 1'b0;
      wait_for_maps();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d map items under %0d register settings, with corner pixels,",
             predictor.checked_maps, $size(plan) + 2);
    $display("saturating coefficients, zero inverse focal lengths and ignored register writes.");
    if (predictor.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
